/* sv/console_bus_address_decoder_unit_assert.svh */
// assertion macros for the bus address decoder
`ifndef CONSOLE_BUS_ADDRESS_DECODER_UNIT_ASSERT_SVH
`define CONSOLE_BUS_ADDRESS_DECODER_UNIT_ASSERT_SVH

// implication in the same cycle
`define CBAD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cbad assertion failed");

// delayed implication: consequence checked after the antecedent
`define CBAD_ASSERT_AFTER2(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
    else $error("cbad assertion failed");

`endif

/* sv/cbad_pkg.sv */
package cbad_pkg;

  localparam logic [2:0] REQ_READ32  = 3'd0;
  localparam logic [2:0] REQ_WRITE32 = 3'd1;
  localparam logic [2:0] REQ_READ16  = 3'd2;
  localparam logic [2:0] REQ_WRITE16 = 3'd3;
  localparam logic [2:0] REQ_READ8   = 3'd4;
  localparam logic [2:0] REQ_WRITE8  = 3'd5;

  localparam logic [3:0] TGT_NONE     = 4'd0;
  localparam logic [3:0] TGT_BIOS     = 4'd1;
  localparam logic [3:0] TGT_RAM      = 4'd2;
  localparam logic [3:0] TGT_MEMCTL   = 4'd3;
  localparam logic [3:0] TGT_RAMSIZE  = 4'd4;
  localparam logic [3:0] TGT_CACHECTL = 4'd5;
  localparam logic [3:0] TGT_IRQ      = 4'd6;
  localparam logic [3:0] TGT_DMA      = 4'd7;
  localparam logic [3:0] TGT_GPU      = 4'd8;
  localparam logic [3:0] TGT_TIMERS   = 4'd9;
  localparam logic [3:0] TGT_SPU      = 4'd10;
  localparam logic [3:0] TGT_EXP1     = 4'd11;
  localparam logic [3:0] TGT_EXP2     = 4'd12;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_UNMAPPED = 2'd1;
  localparam logic [1:0] ST_BAD_EXP1 = 2'd2;
  localparam logic [1:0] ST_BAD_EXP2 = 2'd3;

  localparam logic [2:0]  SEG_KSEG0  = 3'd4;
  localparam logic [2:0]  SEG_KSEG1  = 3'd5;
  localparam logic [31:0] KSEG0_MASK = 32'h7FFF_FFFF;
  localparam logic [31:0] KSEG1_MASK = 32'h1FFF_FFFF;

  localparam logic [31:0] BIOS_BASE     = 32'h1FC0_0000;
  localparam logic [31:0] BIOS_SIZE     = 32'h0008_0000;
  localparam logic [31:0] RAM_BASE      = 32'h0000_0000;
  localparam logic [31:0] MEMCTL_BASE   = 32'h1F80_1000;
  localparam logic [31:0] MEMCTL_SIZE   = 32'd36;
  localparam logic [31:0] RAMSIZE_BASE  = 32'h1F80_1060;
  localparam logic [31:0] RAMSIZE_SIZE  = 32'd4;
  localparam logic [31:0] CACHECTL_BASE = 32'hFFFE_0130;
  localparam logic [31:0] CACHECTL_SIZE = 32'd4;
  localparam logic [31:0] IRQ_BASE      = 32'h1F80_1070;
  localparam logic [31:0] IRQ_SIZE      = 32'd8;
  localparam logic [31:0] DMA_BASE      = 32'h1F80_1080;
  localparam logic [31:0] DMA_SIZE      = 32'h0000_0080;
  localparam logic [31:0] GPU_BASE      = 32'h1F80_1810;
  localparam logic [31:0] GPU_SIZE      = 32'd8;
  localparam logic [31:0] TIMERS_BASE   = 32'h1F80_1100;
  localparam logic [31:0] TIMERS_SIZE   = 32'h0000_0030;
  localparam logic [31:0] SPU_BASE      = 32'h1F80_1C00;
  localparam logic [31:0] SPU_SIZE      = 32'd640;
  localparam logic [31:0] EXP1_BASE     = 32'h1F00_0000;
  localparam logic [31:0] EXP1_SIZE     = 32'h0008_0000;
  localparam logic [31:0] EXP2_BASE     = 32'h1F80_2000;
  localparam logic [31:0] EXP2_SIZE     = 32'd66;

  localparam logic [20:0] GPU_STAT_OFFSET = 21'd4;
  localparam logic [31:0] GPU_STAT_VALUE  = 32'h1000_0000;
  localparam logic [20:0] MEMCTL_EXP1_OFF = 21'd0;
  localparam logic [20:0] MEMCTL_EXP2_OFF = 21'd4;
  localparam logic [31:0] EXP1_STUB_DATA  = 32'h0000_00FF;

  typedef struct packed {
    logic [3:0]  target;
    logic [20:0] offset;
    logic [31:0] physical_address;
    logic        storage_access;
    logic [31:0] read_data;
    logic        misaligned;
    logic [1:0]  status;
  } cbad_result_t;

  function automatic logic span_hit(logic [31:0] a, logic [31:0] base, logic [31:0] size);
    return ((a - base) < size) && (a >= base);
  endfunction

  function automatic logic [20:0] span_off(logic [31:0] a, logic [31:0] base);
    logic [31:0] d;
    d = a - base;
    return d[20:0];
  endfunction

  function automatic logic [31:0] target_base(logic [3:0] t);
    logic [31:0] b;
    unique case (t)
      TGT_BIOS:     b = BIOS_BASE;
      TGT_RAM:      b = RAM_BASE;
      TGT_MEMCTL:   b = MEMCTL_BASE;
      TGT_RAMSIZE:  b = RAMSIZE_BASE;
      TGT_CACHECTL: b = CACHECTL_BASE;
      TGT_IRQ:      b = IRQ_BASE;
      TGT_DMA:      b = DMA_BASE;
      TGT_GPU:      b = GPU_BASE;
      TGT_TIMERS:   b = TIMERS_BASE;
      TGT_SPU:      b = SPU_BASE;
      TGT_EXP1:     b = EXP1_BASE;
      TGT_EXP2:     b = EXP2_BASE;
      default:      b = 32'h0000_0000;
    endcase
    return b;
  endfunction

endpackage

/* sv/cbad_decode.sv */
module cbad_decode #(
  parameter int RAM_BYTES = 2097152
) (
  input  logic [2:0]           req_type,
  input  logic [31:0]          cpu_address,
  input  logic [31:0]          write_data,
  output cbad_pkg::cbad_result_t result
);

  localparam logic [31:0] RAM_SPAN = 32'(RAM_BYTES);

  logic [31:0] phys;
  logic        hit_bios, hit_ram, hit_memctl, hit_ramsize, hit_cachectl, hit_irq;
  logic        hit_dma, hit_gpu, hit_timers, hit_spu, hit_exp1, hit_exp2;
  logic        known;
  logic        is_read;
  logic [3:0]  tgt;
  logic [20:0] off;
  logic        mis;
  logic [31:0] rdata;
  logic [1:0]  st;

  // segment mask
  always_comb begin
    unique case (cpu_address[31:29])
      cbad_pkg::SEG_KSEG0: phys = cpu_address & cbad_pkg::KSEG0_MASK;
      cbad_pkg::SEG_KSEG1: phys = cpu_address & cbad_pkg::KSEG1_MASK;
      default:             phys = cpu_address;
    endcase
  end

  assign hit_bios     = cbad_pkg::span_hit(phys, cbad_pkg::BIOS_BASE, cbad_pkg::BIOS_SIZE);
  assign hit_ram      = cbad_pkg::span_hit(phys, cbad_pkg::RAM_BASE, RAM_SPAN);
  assign hit_memctl   = cbad_pkg::span_hit(phys, cbad_pkg::MEMCTL_BASE,
                                           cbad_pkg::MEMCTL_SIZE);
  assign hit_ramsize  = cbad_pkg::span_hit(phys, cbad_pkg::RAMSIZE_BASE,
                                           cbad_pkg::RAMSIZE_SIZE);
  assign hit_cachectl = cbad_pkg::span_hit(phys, cbad_pkg::CACHECTL_BASE,
                                           cbad_pkg::CACHECTL_SIZE);
  assign hit_irq      = cbad_pkg::span_hit(phys, cbad_pkg::IRQ_BASE, cbad_pkg::IRQ_SIZE);
  assign hit_dma      = cbad_pkg::span_hit(phys, cbad_pkg::DMA_BASE, cbad_pkg::DMA_SIZE);
  assign hit_gpu      = cbad_pkg::span_hit(phys, cbad_pkg::GPU_BASE, cbad_pkg::GPU_SIZE);
  assign hit_timers   = cbad_pkg::span_hit(phys, cbad_pkg::TIMERS_BASE,
                                           cbad_pkg::TIMERS_SIZE);
  assign hit_spu      = cbad_pkg::span_hit(phys, cbad_pkg::SPU_BASE, cbad_pkg::SPU_SIZE);
  assign hit_exp1     = cbad_pkg::span_hit(phys, cbad_pkg::EXP1_BASE, cbad_pkg::EXP1_SIZE);
  assign hit_exp2     = cbad_pkg::span_hit(phys, cbad_pkg::EXP2_BASE, cbad_pkg::EXP2_SIZE);

  assign is_read = ~req_type[0];

  // search order per access kind, first hit wins
  always_comb begin
    tgt   = cbad_pkg::TGT_NONE;
    known = 1'b1;
    unique case (req_type)
      cbad_pkg::REQ_READ32: begin
        priority if (hit_bios) tgt = cbad_pkg::TGT_BIOS;
        else if (hit_ram)      tgt = cbad_pkg::TGT_RAM;
        else if (hit_irq)      tgt = cbad_pkg::TGT_IRQ;
        else if (hit_dma)      tgt = cbad_pkg::TGT_DMA;
        else if (hit_gpu)      tgt = cbad_pkg::TGT_GPU;
        else                   tgt = cbad_pkg::TGT_NONE;
      end
      cbad_pkg::REQ_WRITE32: begin
        priority if (hit_ram)   tgt = cbad_pkg::TGT_RAM;
        else if (hit_memctl)    tgt = cbad_pkg::TGT_MEMCTL;
        else if (hit_ramsize)   tgt = cbad_pkg::TGT_RAMSIZE;
        else if (hit_cachectl)  tgt = cbad_pkg::TGT_CACHECTL;
        else if (hit_irq)       tgt = cbad_pkg::TGT_IRQ;
        else if (hit_dma)       tgt = cbad_pkg::TGT_DMA;
        else if (hit_gpu)       tgt = cbad_pkg::TGT_GPU;
        else if (hit_timers)    tgt = cbad_pkg::TGT_TIMERS;
        else                    tgt = cbad_pkg::TGT_NONE;
      end
      cbad_pkg::REQ_READ16: begin
        priority if (hit_ram) tgt = cbad_pkg::TGT_RAM;
        else if (hit_spu)     tgt = cbad_pkg::TGT_SPU;
        else if (hit_irq)     tgt = cbad_pkg::TGT_IRQ;
        else                  tgt = cbad_pkg::TGT_NONE;
      end
      cbad_pkg::REQ_WRITE16: begin
        priority if (hit_ram) tgt = cbad_pkg::TGT_RAM;
        else if (hit_spu)     tgt = cbad_pkg::TGT_SPU;
        else if (hit_timers)  tgt = cbad_pkg::TGT_TIMERS;
        else if (hit_irq)     tgt = cbad_pkg::TGT_IRQ;
        else                  tgt = cbad_pkg::TGT_NONE;
      end
      cbad_pkg::REQ_READ8: begin
        priority if (hit_ram) tgt = cbad_pkg::TGT_RAM;
        else if (hit_bios)    tgt = cbad_pkg::TGT_BIOS;
        else if (hit_exp1)    tgt = cbad_pkg::TGT_EXP1;
        else                  tgt = cbad_pkg::TGT_NONE;
      end
      cbad_pkg::REQ_WRITE8: begin
        priority if (hit_ram) tgt = cbad_pkg::TGT_RAM;
        else if (hit_exp2)    tgt = cbad_pkg::TGT_EXP2;
        else                  tgt = cbad_pkg::TGT_NONE;
      end
      default: begin
        tgt   = cbad_pkg::TGT_NONE;
        known = 1'b0;
      end
    endcase
  end

  assign off = (tgt == cbad_pkg::TGT_NONE) ? 21'd0
             : cbad_pkg::span_off(phys, cbad_pkg::target_base(tgt));

  // alignment checked on the virtual address
  always_comb begin
    unique case (req_type)
      cbad_pkg::REQ_READ32,
      cbad_pkg::REQ_WRITE32: mis = |cpu_address[1:0];
      cbad_pkg::REQ_WRITE16: mis = cpu_address[0];
      default:               mis = 1'b0;
    endcase
  end

  always_comb begin
    rdata = 32'h0000_0000;
    st    = cbad_pkg::ST_OK;
    priority if (!known) begin
      st = cbad_pkg::ST_UNMAPPED;
    end else if (tgt == cbad_pkg::TGT_NONE) begin
      st = cbad_pkg::ST_UNMAPPED;
      if (is_read) begin
        priority if (req_type == cbad_pkg::REQ_READ32) rdata = 32'hFFFF_FFFF;
        else if (req_type == cbad_pkg::REQ_READ16)     rdata = 32'h0000_FFFF;
        else                                           rdata = 32'h0000_00FF;
      end
    end else if (is_read) begin
      if (tgt == cbad_pkg::TGT_GPU && off == cbad_pkg::GPU_STAT_OFFSET) begin
        rdata = cbad_pkg::GPU_STAT_VALUE;
      end else if (tgt == cbad_pkg::TGT_EXP1) begin
        rdata = cbad_pkg::EXP1_STUB_DATA;
      end
    end else if (req_type == cbad_pkg::REQ_WRITE32 && tgt == cbad_pkg::TGT_MEMCTL) begin
      // expansion base registers only accept their fixed values
      if (off == cbad_pkg::MEMCTL_EXP1_OFF && write_data != cbad_pkg::EXP1_BASE) begin
        st = cbad_pkg::ST_BAD_EXP1;
      end else if (off == cbad_pkg::MEMCTL_EXP2_OFF && write_data != cbad_pkg::EXP2_BASE) begin
        st = cbad_pkg::ST_BAD_EXP2;
      end
    end
  end

  assign result.target           = tgt;
  assign result.offset           = off;
  assign result.physical_address = phys;
  assign result.storage_access   = (tgt == cbad_pkg::TGT_RAM) || (tgt == cbad_pkg::TGT_BIOS);
  assign result.read_data        = rdata;
  assign result.misaligned       = mis;
  assign result.status           = st;

endmodule

/* sv/console_bus_address_decoder_unit.sv */
// cpu bus address decoder: segment mask, then memory map decode per access kind
// result strobe (done) is registered from in_valid, which is registered from the accepting start
// throughput: one transaction per cycle; input register, decode, result register
// busy is never raised and the receiver cannot stall the result
// reset (rst, synchronous) clears the pipeline valid bits only
`include "console_bus_address_decoder_unit_assert.svh"

module console_bus_address_decoder_unit #(
  parameter int RAM_BYTES = 2097152
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  req_type,
  input  logic [31:0] cpu_address,
  input  logic [31:0] write_data,
  output logic        done,
  output logic [3:0]  target,
  output logic [20:0] offset,
  output logic [31:0] physical_address,
  output logic        storage_access,
  output logic [31:0] read_data,
  output logic        misaligned,
  output logic [1:0]  status
);

  logic                   in_valid;
  logic [2:0]             req_q;
  logic [31:0]            addr_q;
  logic [31:0]            data_q;
  cbad_pkg::cbad_result_t dec_result;
  cbad_pkg::cbad_result_t res_q;
  logic                   accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      in_valid <= accept;
      done     <= in_valid;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q  <= req_type;
      addr_q <= cpu_address;
      data_q <= write_data;
    end
    if (in_valid) begin
      res_q <= dec_result;
    end
  end

  cbad_decode #(
    .RAM_BYTES (RAM_BYTES)
  ) u_decode (
    .req_type    (req_q),
    .cpu_address (addr_q),
    .write_data  (data_q),
    .result      (dec_result)
  );

  assign target           = res_q.target;
  assign offset           = res_q.offset;
  assign physical_address = res_q.physical_address;
  assign storage_access   = res_q.storage_access;
  assign read_data        = res_q.read_data;
  assign misaligned       = res_q.misaligned;
  assign status           = res_q.status;

  `CBAD_ASSERT_AFTER2(a_start_gives_done, clk, rst, accept, done)
  `CBAD_ASSERT_IMPLY(a_bad_base_is_memctl, clk, rst,
    done && (status == cbad_pkg::ST_BAD_EXP1 || status == cbad_pkg::ST_BAD_EXP2),
    target == cbad_pkg::TGT_MEMCTL)
  `CBAD_ASSERT_IMPLY(a_unmapped_no_target, clk, rst,
    done && status == cbad_pkg::ST_UNMAPPED,
    target == cbad_pkg::TGT_NONE && offset == 21'd0 && !storage_access)
  `CBAD_ASSERT_IMPLY(a_storage_read_zero, clk, rst,
    done && storage_access, read_data == 32'h0000_0000 && status == cbad_pkg::ST_OK)

endmodule
